[design/clsn_pkg.sv]
`timescale 1ns / 1ps

package clsn_pkg;

   // Block defaults.
   localparam int CHANNELS_DEFAULT      = 2;
   localparam int DELAY_SAMPLES_DEFAULT = 250;

   // Field widths.
   localparam int CHANNEL_W = 4;
   localparam int LEVEL_W   = 17;
   localparam int WEIGHT_W  = 24;
   localparam int RATE_W    = 16;
   localparam int PTR_W     = 8;
   localparam int SLOT_W    = 8;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   localparam logic [CSR_INDEX_W-1:0] REG_SPLIT_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LEARN_RATE      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LEARNING_ENABLE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_GAIN     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PROLONG_GAIN    = 3'd4;

   localparam logic [LEVEL_W-1:0] SPLIT_THRESHOLD_RESET = 17'd58982;
   localparam logic [RATE_W-1:0]  LEARN_RATE_RESET      = 16'd4096;
   localparam logic [LEVEL_W-1:0] FILTER_GAIN_RESET     = 17'd6554;
   localparam logic [LEVEL_W-1:0] PROLONG_GAIN_RESET    = 17'd6554;

   localparam logic [LEVEL_W-1:0]  ONE_Q16   = 17'd65536;
   localparam logic [WEIGHT_W-1:0] HALF_Q16  = 24'd32768;
   localparam logic [WEIGHT_W-1:0] W_MAX     = 24'hFFFFFF;

   // Shared multiplier operand widths.
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 26;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRED,
      ST_REFL,
      ST_RATE,
      ST_RISE,
      ST_WUPD,
      ST_WMUL,
      ST_LRN,
      ST_PROL,
      ST_DLY,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_PRED,
      MUL_REFL,
      MUL_RATE,
      MUL_RISE,
      MUL_WEIGHT,
      MUL_PROL
   } mul_sel_type;

   typedef struct packed {
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        upd_pred;
      logic        upd_newr;
      logic        upd_weight;
      logic        upd_learned;
      logic        write_back;
      logic        load_rsp;
   } ctrl_type;

   // Rounded first-order low-pass: (level << 16) + gain * (x - level) + half, >> 16.
   function automatic logic [24:0] lp_result(input logic [WEIGHT_W-1:0] level,
                                             input logic signed [PROD_W-1:0] prod);
      logic signed [47:0] acc;
      acc = $signed({8'd0, level, 16'd0}) + $signed(prod[47:0]) + $signed({24'd0, HALF_Q16});
      return acc[40:16];
   endfunction

endpackage

[design/clsn_mul.sv]
`timescale 1ns / 1ps

module clsn_mul (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [clsn_pkg::MUL_A_W-1:0]  a,
   input  logic signed [clsn_pkg::MUL_B_W-1:0]  b,
   output logic signed [clsn_pkg::PROD_W-1:0]   prod
);

   logic signed [clsn_pkg::PROD_W-1:0] prod_ff;
   logic signed [clsn_pkg::PROD_W-1:0] prod_in;

   assign prod_in = clsn_pkg::PROD_W'(a) * clsn_pkg::PROD_W'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

[design/clsn_delay_ram.sv]
`timescale 1ns / 1ps

module clsn_delay_ram #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9,
   parameter int DATA_W = 24
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/correlation_learning_sensor_neuron.sv]
`timescale 1ns / 1ps

// Input-correlation learning neuron for range-sensor channels, Q1.16 fixed point.
// Each request carries one channel's sample; a sample below split_threshold feeds the
// predictive path and any other sample the reflex path, both low-pass filtered. While
// learning is enabled the channel's weight grows with rate times predictive level times
// the rise of the reflex level; the product of weight and predictive level is low-pass
// prolonged, delayed by DELAY_SAMPLES requests of that channel, doubled and clipped to
// 1.0. An in-range request runs through nine steps around a single registered 34 x 26
// multiplier, six of which use it, and one output step, in which its result is loaded;
// no new request is accepted before the block is back in its idle step. A result that
// is still waiting holds the block in its output step until the result is taken. A channel
// index at or above CHANNELS goes straight from acceptance to the output step, returns
// zero drive and weight and changes no state. The delay store is a RAM of CHANNELS x 256
// words with a per-channel filled flag, so no clearing pass is needed after reset.
// The user must write configuration only while idle; the block does not enforce this.

module correlation_learning_sensor_neuron #(
   parameter int CHANNELS      = clsn_pkg::CHANNELS_DEFAULT,
   parameter int DELAY_SAMPLES = clsn_pkg::DELAY_SAMPLES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: channel [3:0], sample [20:4], zero fill [23:21].
   input  logic [23:0]                        req_tdata,

   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: out_channel [3:0], drive_value [20:4], learned_weight [44:21],
   // zero fill [47:45].
   output logic [47:0]                        rsp_tdata,

   input  logic                               csr_we,
   input  logic [clsn_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [clsn_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ADDR_W = CH_W + clsn_pkg::SLOT_W;
   localparam int DEPTH  = CHANNELS * (2 ** clsn_pkg::SLOT_W);
   localparam logic [clsn_pkg::PTR_W-1:0] PTR_LAST = clsn_pkg::PTR_W'(DELAY_SAMPLES - 1);

   localparam int LW = clsn_pkg::LEVEL_W;
   localparam int WW = clsn_pkg::WEIGHT_W;

   // Configuration registers; gains are stored already clipped to 1.0.
   logic [LW-1:0]                 thresh_ff;
   logic [clsn_pkg::RATE_W-1:0]   rate_ff;
   logic                          learn_en_ff;
   logic [LW-1:0]                 fgain_ff;
   logic [LW-1:0]                 pgain_ff;
   logic [LW-1:0]                 csr_gain;

   // Per-channel state.
   logic [LW-1:0]                 pred_arr_ff [CHANNELS];
   logic [LW-1:0]                 refl_arr_ff [CHANNELS];
   logic [WW-1:0]                 wt_arr_ff   [CHANNELS];
   logic [WW-1:0]                 prol_arr_ff [CHANNELS];
   logic [clsn_pkg::PTR_W-1:0]    ptr_arr_ff  [CHANNELS];
   logic                          full_arr_ff [CHANNELS];

   // Working registers of the request in flight.
   clsn_pkg::state_type           state_ff, state_in;
   clsn_pkg::ctrl_type            ctrl;
   logic [clsn_pkg::CHANNEL_W-1:0] ch_ff;
   logic [CH_W-1:0]               idx_ff;
   logic                          inrange_ff;
   logic [LW-1:0]                 pin_ff, rin_ff;
   logic [LW-1:0]                 pred_ff, oldr_ff, newr_ff;
   logic [WW-1:0]                 w_ff, prol_ff, learned_ff;
   logic [clsn_pkg::PTR_W-1:0]    ptr_ff;
   logic                          full_ff;

   logic                          rsp_valid_ff;
   logic [clsn_pkg::CHANNEL_W-1:0] rsp_ch_ff;
   logic [LW-1:0]                 rsp_drive_ff;
   logic [WW-1:0]                 rsp_wt_ff;

   logic                          accept;
   logic [clsn_pkg::CHANNEL_W-1:0] req_ch;
   logic [LW-1:0]                 req_sample, req_clip;
   logic                          req_inrange;
   logic [CH_W-1:0]               req_idx;

   logic signed [clsn_pkg::MUL_A_W-1:0] mul_a;
   logic signed [clsn_pkg::MUL_B_W-1:0] mul_b;
   logic signed [clsn_pkg::PROD_W-1:0]  prod;
   logic signed [LW:0]            diff_pred, diff_refl, rise;
   logic signed [WW:0]            diff_prol;
   logic                          rising;
   logic [24:0]                   lp_out;
   logic [WW:0]                   w_sum;
   logic [WW-1:0]                 w_new;
   logic [clsn_pkg::PTR_W-1:0]    ptr_next;
   logic [WW-1:0]                 delayed;
   logic [LW-1:0]                 drive;
   logic [WW-1:0]                 ram_q;

   assign req_ch      = req_tdata[3:0];
   assign req_sample  = req_tdata[20:4];
   assign req_clip    = (req_sample > clsn_pkg::ONE_Q16) ? clsn_pkg::ONE_Q16 : req_sample;
   assign req_inrange = ({1'b0, req_ch} < 5'(CHANNELS));
   assign req_idx     = req_inrange ? req_ch[CH_W-1:0] : '0;

   assign req_tready = (state_ff == clsn_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Configuration writes.
   assign csr_gain = (csr_wdata > clsn_pkg::ONE_Q16) ? clsn_pkg::ONE_Q16 : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff   <= clsn_pkg::SPLIT_THRESHOLD_RESET;
         rate_ff     <= clsn_pkg::LEARN_RATE_RESET;
         learn_en_ff <= 1'b1;
         fgain_ff    <= clsn_pkg::FILTER_GAIN_RESET;
         pgain_ff    <= clsn_pkg::PROLONG_GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            clsn_pkg::REG_SPLIT_THRESHOLD: thresh_ff   <= csr_wdata;
            clsn_pkg::REG_LEARN_RATE:      rate_ff     <= csr_wdata[clsn_pkg::RATE_W-1:0];
            clsn_pkg::REG_LEARNING_ENABLE: learn_en_ff <= csr_wdata[0];
            clsn_pkg::REG_FILTER_GAIN:     fgain_ff    <= csr_gain;
            clsn_pkg::REG_PROLONG_GAIN:    pgain_ff    <= csr_gain;
            default: ;
         endcase
      end
   end

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         clsn_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = req_inrange ? clsn_pkg::ST_PRED : clsn_pkg::ST_OUT;
            end
         end
         clsn_pkg::ST_PRED: state_in = clsn_pkg::ST_REFL;
         clsn_pkg::ST_REFL: state_in = clsn_pkg::ST_RATE;
         clsn_pkg::ST_RATE: state_in = clsn_pkg::ST_RISE;
         clsn_pkg::ST_RISE: state_in = clsn_pkg::ST_WUPD;
         clsn_pkg::ST_WUPD: state_in = clsn_pkg::ST_WMUL;
         clsn_pkg::ST_WMUL: state_in = clsn_pkg::ST_LRN;
         clsn_pkg::ST_LRN:  state_in = clsn_pkg::ST_PROL;
         clsn_pkg::ST_PROL: state_in = clsn_pkg::ST_DLY;
         clsn_pkg::ST_DLY:  state_in = clsn_pkg::ST_OUT;
         clsn_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = clsn_pkg::ST_IDLE;
            end
         end
         default: state_in = clsn_pkg::ST_IDLE;
      endcase
   end

   // Sequencer: control outputs.
   always_comb begin
      ctrl = '0;
      ctrl.mul_sel = clsn_pkg::MUL_PRED;
      unique case (state_ff)
         clsn_pkg::ST_IDLE: ;
         clsn_pkg::ST_PRED: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = clsn_pkg::MUL_PRED;
         end
         clsn_pkg::ST_REFL: begin
            ctrl.upd_pred = 1'b1;
            ctrl.mul_en   = 1'b1;
            ctrl.mul_sel  = clsn_pkg::MUL_REFL;
         end
         clsn_pkg::ST_RATE: begin
            ctrl.upd_newr = 1'b1;
            ctrl.mul_en   = 1'b1;
            ctrl.mul_sel  = clsn_pkg::MUL_RATE;
         end
         clsn_pkg::ST_RISE: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = clsn_pkg::MUL_RISE;
         end
         clsn_pkg::ST_WUPD: ctrl.upd_weight = 1'b1;
         clsn_pkg::ST_WMUL: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = clsn_pkg::MUL_WEIGHT;
         end
         clsn_pkg::ST_LRN:  ctrl.upd_learned = 1'b1;
         clsn_pkg::ST_PROL: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = clsn_pkg::MUL_PROL;
         end
         clsn_pkg::ST_DLY:  ctrl.write_back = 1'b1;
         clsn_pkg::ST_OUT:  ctrl.load_rsp = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clsn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Operand selection for the shared multiplier.
   assign diff_pred = $signed({1'b0, pin_ff}) - $signed({1'b0, pred_ff});
   assign diff_refl = $signed({1'b0, rin_ff}) - $signed({1'b0, oldr_ff});
   assign rise      = $signed({1'b0, newr_ff}) - $signed({1'b0, oldr_ff});
   assign diff_prol = $signed({1'b0, learned_ff}) - $signed({1'b0, prol_ff});
   assign rising    = newr_ff > oldr_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.mul_sel)
         clsn_pkg::MUL_PRED: begin
            mul_a = $signed({17'd0, fgain_ff});
            mul_b = clsn_pkg::MUL_B_W'(diff_pred);
         end
         clsn_pkg::MUL_REFL: begin
            mul_a = $signed({17'd0, fgain_ff});
            mul_b = clsn_pkg::MUL_B_W'(diff_refl);
         end
         clsn_pkg::MUL_RATE: begin
            mul_a = $signed({18'd0, rate_ff});
            mul_b = $signed({9'd0, pred_ff});
         end
         clsn_pkg::MUL_RISE: begin
            mul_a = $signed({1'b0, prod[32:0]});
            mul_b = clsn_pkg::MUL_B_W'(rise);
         end
         clsn_pkg::MUL_WEIGHT: begin
            mul_a = $signed({10'd0, w_ff});
            mul_b = $signed({9'd0, pred_ff});
         end
         clsn_pkg::MUL_PROL: begin
            mul_a = $signed({17'd0, pgain_ff});
            mul_b = clsn_pkg::MUL_B_W'(diff_prol);
         end
         default: ;
      endcase
   end

   clsn_mul u_mul (
      .clock (clock),
      .en    (ctrl.mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // Post-multiply arithmetic.
   always_comb begin
      lp_out = clsn_pkg::lp_result(prol_ff, prod);
      case (state_ff)
         clsn_pkg::ST_REFL: lp_out = clsn_pkg::lp_result({7'd0, pred_ff}, prod);
         clsn_pkg::ST_RATE: lp_out = clsn_pkg::lp_result({7'd0, oldr_ff}, prod);
         default: ;
      endcase
   end

   assign w_sum = {1'b0, w_ff} + {3'd0, prod[49:28]};
   assign w_new = w_sum[WW] ? clsn_pkg::W_MAX : w_sum[WW-1:0];
   assign ptr_next = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff      <= req_ch;
         idx_ff     <= req_idx;
         inrange_ff <= req_inrange;
         if (req_sample < thresh_ff) begin
            pin_ff <= req_clip;
            rin_ff <= '0;
         end else begin
            pin_ff <= '0;
            rin_ff <= req_clip;
         end
         pred_ff <= pred_arr_ff[req_idx];
         oldr_ff <= refl_arr_ff[req_idx];
         w_ff    <= wt_arr_ff[req_idx];
         prol_ff <= prol_arr_ff[req_idx];
         ptr_ff  <= ptr_arr_ff[req_idx];
         full_ff <= full_arr_ff[req_idx];
      end
      if (ctrl.upd_pred) begin
         pred_ff <= lp_out[LW-1:0];
      end
      if (ctrl.upd_newr) begin
         newr_ff <= lp_out[LW-1:0];
      end
      // The weight only moves while learning is on and the reflex level rises.
      if (ctrl.upd_weight && learn_en_ff && rising) begin
         w_ff <= w_new;
      end
      if (ctrl.upd_learned) begin
         learned_ff <= prod[39:16];
      end
   end

   // Per-channel state write-back.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            pred_arr_ff[i] <= '0;
            refl_arr_ff[i] <= '0;
            wt_arr_ff[i]   <= '0;
            prol_arr_ff[i] <= '0;
            ptr_arr_ff[i]  <= '0;
            full_arr_ff[i] <= 1'b0;
         end
      end else if (ctrl.write_back) begin
         pred_arr_ff[idx_ff] <= pred_ff;
         refl_arr_ff[idx_ff] <= learn_en_ff ? newr_ff : '0;
         wt_arr_ff[idx_ff]   <= w_ff;
         prol_arr_ff[idx_ff] <= lp_out[WW-1:0];
         ptr_arr_ff[idx_ff]  <= ptr_next;
         if (ptr_ff == PTR_LAST) begin
            full_arr_ff[idx_ff] <= 1'b1;
         end
      end
   end

   clsn_delay_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (WW)
   ) u_delay_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr ({req_idx, ptr_arr_ff[req_idx]}),
      .rd_data (ram_q),
      .wr_en   (ctrl.write_back),
      .wr_addr ({idx_ff, ptr_ff}),
      .wr_data (lp_out[WW-1:0])
   );

   // A slot that has not yet been written for this channel reads as zero.
   assign delayed = full_ff ? ram_q : '0;
   assign drive   = (delayed >= clsn_pkg::HALF_Q16) ? clsn_pkg::ONE_Q16 : {delayed[15:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_rsp) begin
         rsp_ch_ff    <= ch_ff;
         rsp_drive_ff <= inrange_ff ? drive : '0;
         rsp_wt_ff    <= inrange_ff ? w_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_wt_ff, rsp_drive_ff, rsp_ch_ff};

   // Checks.
   a_wb_in_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.write_back |-> inrange_ff)
      else $error("state write-back for a channel out of range");

   a_weight_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff == clsn_pkg::ST_WUPD) |=> (w_ff >= $past(w_ff)))
      else $error("learned weight decreased");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("new request taken while one is in flight");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff != clsn_pkg::ST_IDLE) && inrange_ff) |-> (ptr_ff <= PTR_LAST))
      else $error("delay pointer beyond the delay length");

endmodule
